FILE: rtl/flv_avc_tag_to_annexb_macros.svh
// Assertion macros used by the checker file fa2b_checker.sv.
`ifndef FLV_AVC_TAG_TO_ANNEXB_MACROS_SVH
`define FLV_AVC_TAG_TO_ANNEXB_MACROS_SVH

// Combinational check under reset qualification.
`define FA2B_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fa2b checker: property failed");

// Implication check: antecedent now, consequent on the next edge.
`define FA2B_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fa2b checker: property failed");

`endif

FILE: rtl/fa2b_pkg.sv
// ----------------------------------------------------------------------------
// fa2b_pkg
// Types and constants for the FLV AVC tag to Annex-B converter.
// ----------------------------------------------------------------------------
package fa2b_pkg;

    typedef enum logic [4:0] {
        PH_FIRST  = 5'b00001,
        PH_HEAD   = 5'b00010,
        PH_PREFIX = 5'b00100,
        PH_BODY   = 5'b01000,
        PH_DROP   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        OP_ONE   = 2'd0,
        OP_TRUNC = 2'd1,
        OP_START = 2'd2
    } op_t;

    localparam logic [1:0] KIND_HDR   = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_UNSUP = 2'd2;
    localparam logic [1:0] KIND_TRUNC = 2'd3;

    localparam logic [3:0] CODEC_AVC    = 4'd7;
    localparam logic [7:0] PT_NALU      = 8'd1;
    localparam logic [2:0] PREFIX_RESET = 3'd4;
    localparam logic [2:0] PREFIX_MIN   = 3'd1;
    localparam logic [2:0] PREFIX_MAX   = 3'd4;
    localparam logic [1:0] HDR_LAST     = 2'd3;
    localparam logic [1:0] SC_LAST      = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       tag_end;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [3:0]  frame_type;
        logic [3:0]  codec_id;
        logic [7:0]  packet_type;
        logic [23:0] composition_time;
        logic        run_last;
        logic        tag_done;
    } out_t;

    typedef struct packed {
        op_t  op;
        out_t res;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // start code 00 00 00 01
    function automatic logic [7:0] start_byte(input logic [1:0] idx);
        logic [7:0] b;
        b = (idx == SC_LAST) ? 8'd1 : 8'd0;
        return b;
    endfunction

endpackage

FILE: rtl/fa2b_front.sv
// ----------------------------------------------------------------------------
// fa2b_front
// Tag parser: tracks the tag phase and turns each byte into a command word.
// ----------------------------------------------------------------------------
module fa2b_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_data,
    input  logic          acc,
    input  fa2b_pkg::in_t in_word,
    output logic          cmd_vld,
    output fa2b_pkg::cmd_t cmd
);
    import fa2b_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]  pfx_cnt_reg, pfx_cnt_next;
    logic [31:0] nal_reg, nal_next;
    logic [3:0]  ft_reg, ft_next;
    logic [3:0]  cid_reg, cid_next;
    logic [7:0]  pt_reg, pt_next;
    logic [23:0] ct_reg, ct_next;
    logic [2:0]  pfx_reg;

    logic [2:0]  need;
    logic [2:0]  got;
    logic [31:0] nal_acc;
    logic [31:0] nal_dec;
    logic [7:0]  b;
    logic        tend;

    assign b    = in_word.in_byte;
    assign tend = in_word.tag_end;
    assign got  = {1'b0, pfx_cnt_reg} + 3'd1;
    assign nal_acc = {nal_reg[23:0], b};
    assign nal_dec = nal_reg - 32'd1;

    always_comb
    begin
        if (pfx_reg < PREFIX_MIN)
            need = PREFIX_MIN;
        else if (pfx_reg > PREFIX_MAX)
            need = PREFIX_MAX;
        else
            need = pfx_reg;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        pfx_cnt_next = pfx_cnt_reg;
        nal_next     = nal_reg;
        ft_next      = ft_reg;
        cid_next     = cid_reg;
        pt_next      = pt_reg;
        ct_next      = ct_reg;
        cmd_vld      = 1'b0;
        cmd          = '0;
        cmd.op       = OP_ONE;

        case (phase_reg)
            PH_FIRST:
            begin
                ft_next      = b[7:4];
                cid_next     = b[3:0];
                pt_next      = '0;
                ct_next      = '0;
                hdr_cnt_next = '0;
                pfx_cnt_next = '0;
                nal_next     = '0;
                cmd.res.frame_type = b[7:4];
                cmd.res.codec_id   = b[3:0];
                cmd.res.tag_done   = 1'b1;
                if (b[3:0] != CODEC_AVC)
                begin
                    cmd_vld      = 1'b1;
                    cmd.res.kind = KIND_UNSUP;
                    phase_next   = PH_DROP;
                end
                else
                begin
                    cmd_vld      = tend;
                    cmd.res.kind = KIND_TRUNC;
                    phase_next   = PH_HEAD;
                end
            end
            PH_HEAD:
            begin
                if (hdr_cnt_reg == 2'd0)
                    pt_next = b;
                else
                    ct_next = {ct_reg[15:0], b};
                cmd.res.frame_type = ft_reg;
                cmd.res.codec_id   = cid_reg;
                if (hdr_cnt_reg == HDR_LAST)
                begin
                    hdr_cnt_next = '0;
                    cmd_vld      = 1'b1;
                    cmd.res.kind = KIND_HDR;
                    cmd.res.packet_type      = pt_next;
                    cmd.res.composition_time = ct_next;
                    cmd.res.tag_done = tend || (pt_next != PT_NALU);
                    phase_next = (pt_next == PT_NALU) ? PH_PREFIX : PH_DROP;
                end
                else
                begin
                    hdr_cnt_next     = hdr_cnt_reg + 2'd1;
                    cmd_vld          = tend;
                    cmd.res.kind     = KIND_TRUNC;
                    cmd.res.tag_done = 1'b1;
                end
            end
            PH_PREFIX:
            begin
                nal_next = nal_acc;
                cmd.res.frame_type       = ft_reg;
                cmd.res.codec_id         = cid_reg;
                cmd.res.packet_type      = pt_reg;
                cmd.res.composition_time = ct_reg;
                cmd.res.kind             = KIND_TRUNC;
                cmd.res.tag_done         = 1'b1;
                if (got >= need)
                begin
                    pfx_cnt_next = '0;
                    if (tend && (nal_acc != 32'd0))
                        cmd_vld = 1'b1;
                    else
                    begin
                        cmd_vld          = 1'b1;
                        cmd.op           = OP_START;
                        cmd.res.frame_type       = '0;
                        cmd.res.codec_id         = '0;
                        cmd.res.packet_type      = '0;
                        cmd.res.composition_time = '0;
                        cmd.res.tag_done = tend;
                        phase_next = (nal_acc != 32'd0) ? PH_BODY : PH_PREFIX;
                    end
                end
                else
                begin
                    pfx_cnt_next = got[1:0];
                    cmd_vld      = tend;
                end
            end
            PH_BODY:
            begin
                nal_next          = nal_dec;
                cmd_vld           = 1'b1;
                cmd.res.data_byte = b;
                if (tend && (nal_dec != 32'd0))
                begin
                    cmd.op                   = OP_TRUNC;
                    cmd.res.kind             = KIND_TRUNC;
                    cmd.res.frame_type       = ft_reg;
                    cmd.res.codec_id         = cid_reg;
                    cmd.res.packet_type      = pt_reg;
                    cmd.res.composition_time = ct_reg;
                    cmd.res.tag_done         = 1'b1;
                end
                else
                begin
                    cmd.res.kind     = KIND_BYTE;
                    cmd.res.tag_done = tend;
                end
                if (nal_dec == 32'd0)
                    phase_next = PH_PREFIX;
            end
            PH_DROP:
            begin
                cmd_vld = 1'b0;
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase

        if (tend)
        begin
            phase_next   = PH_FIRST;
            hdr_cnt_next = '0;
            pfx_cnt_next = '0;
            nal_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            hdr_cnt_reg <= '0;
            pfx_cnt_reg <= '0;
            nal_reg     <= '0;
            ft_reg      <= '0;
            cid_reg     <= '0;
            pt_reg      <= '0;
            ct_reg      <= '0;
        end
        else if (acc)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            pfx_cnt_reg <= pfx_cnt_next;
            nal_reg     <= nal_next;
            ft_reg      <= ft_next;
            cid_reg     <= cid_next;
            pt_reg      <= pt_next;
            ct_reg      <= ct_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pfx_reg <= PREFIX_RESET;
        else if (cfg_we)
            pfx_reg <= cfg_data;
    end

endmodule

FILE: rtl/fa2b_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fa2b_cmd_fifo
// Short command queue between the parser and the result generator.
// ----------------------------------------------------------------------------
module fa2b_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  fa2b_pkg::cmd_t      wr_data,
    input  logic                rd_en,
    output fa2b_pkg::cmd_t      rd_data,
    output fa2b_pkg::fifo_stat_t stat
);
    import fa2b_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !stat.full;
    assign do_rd   = rd_en && !stat.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: rtl/fa2b_back.sv
// ----------------------------------------------------------------------------
// fa2b_back
// Result generator: expands command words into result words.
// ----------------------------------------------------------------------------
module fa2b_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fa2b_pkg::cmd_t       head,
    input  fa2b_pkg::fifo_stat_t stat,
    output logic                 cmd_pop,
    input  logic                 pop,
    output logic                 empty,
    output fa2b_pkg::out_t       out_word
);
    import fa2b_pkg::*;

    logic       ovld_reg, ovld_next;
    out_t       res_reg;
    logic [1:0] idx_reg, idx_next;
    out_t       res;
    logic       last;
    logic       load;

    always_comb
    begin
        res          = head.res;
        res.run_last = 1'b0;
        last         = 1'b1;
        case (head.op)
            OP_ONE:
            begin
                last = 1'b1;
            end
            OP_TRUNC:
            begin
                if (idx_reg == 2'd0)
                begin
                    res.kind             = KIND_BYTE;
                    res.frame_type       = '0;
                    res.codec_id         = '0;
                    res.packet_type      = '0;
                    res.composition_time = '0;
                    res.tag_done         = 1'b0;
                    last                 = 1'b0;
                end
                else
                    res.data_byte = '0;
            end
            OP_START:
            begin
                last          = (idx_reg == SC_LAST);
                res.kind      = KIND_BYTE;
                res.data_byte = start_byte(idx_reg);
                res.tag_done  = head.res.tag_done && last;
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
        res.run_last = last;
    end

    assign load    = !stat.empty && (!ovld_reg || pop);
    assign cmd_pop = load && last;
    assign empty   = !ovld_reg;
    assign out_word = res_reg;

    always_comb
    begin
        idx_next  = idx_reg;
        ovld_next = ovld_reg;
        if (load)
        begin
            idx_next  = last ? 2'd0 : idx_reg + 2'd1;
            ovld_next = 1'b1;
        end
        else if (pop)
            ovld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            ovld_reg <= ovld_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

FILE: rtl/flv_avc_tag_to_annexb.sv
// A taken byte's command enters the command queue and is expanded into result
// words in out_word. Throughput: one tag byte per cycle while not full; results
// leave one per cycle while popped, so a byte ending a length prefix expands to
// four words (start code) and a NAL byte truncating a tag to two, the command
// queue absorbing the burst. Reset: rst_n is asynchronous; parser, queue and
// output go empty, pfx_reg returns to 4. No clearing pass.
// ----------------------------------------------------------------------------
// flv_avc_tag_to_annexb
// FLV AVC video tag body to Annex-B byte stream converter, top level.
// ----------------------------------------------------------------------------
module flv_avc_tag_to_annexb #(
    parameter int CMD_DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  fa2b_pkg::in_t  in_word,
    output logic           empty,
    input  logic           pop,
    output fa2b_pkg::out_t out_word,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_data
);
    import fa2b_pkg::*;

    logic       acc;
    logic       cmd_vld;
    cmd_t       cmd;
    cmd_t       head;
    fifo_stat_t stat;
    logic       cmd_pop;

    assign cfg_ready = 1'b1;
    assign full      = stat.full;
    assign acc       = push && !stat.full;

    fa2b_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .acc      (acc),
        .in_word  (in_word),
        .cmd_vld  (cmd_vld),
        .cmd      (cmd)
    );

    fa2b_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (acc && cmd_vld),
        .wr_data (cmd),
        .rd_en   (cmd_pop),
        .rd_data (head),
        .stat    (stat)
    );

    fa2b_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .stat     (stat),
        .cmd_pop  (cmd_pop),
        .pop      (pop),
        .empty    (empty),
        .out_word (out_word)
    );

endmodule

FILE: rtl/fa2b_checker.sv
// ----------------------------------------------------------------------------
// fa2b_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "flv_avc_tag_to_annexb_macros.svh"

module fa2b_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           empty,
    input logic           pop,
    input fa2b_pkg::out_t out_word
);
    import fa2b_pkg::*;

    `FA2B_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_word))
    `FA2B_ASSERT_NEXT(a_run_cont, !empty && pop && !out_word.run_last, !empty)
    `FA2B_ASSERT_NOW(a_done_last, empty || !out_word.tag_done || out_word.run_last)
    `FA2B_ASSERT_NOW(a_data_zero, empty || out_word.kind == KIND_BYTE || out_word.data_byte == 8'd0)

endmodule

bind flv_avc_tag_to_annexb fa2b_checker u_fa2b_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
);

FILE: tb/fa2b_annexb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fa2b_annexb_checker
// Watches the tag byte, result and prefix-width channels of the converter,
// predicts the Annex-B result words of every accepted tag byte and compares
// each popped word with the oldest prediction.
// ----------------------------------------------------------------------------
module fa2b_annexb_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           full,
    input  fa2b_pkg::in_t  in_word,
    input  logic           empty,
    input  logic           pop,
    input  fa2b_pkg::out_t out_word,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [2:0]     cfg_data,
    output int             errors,
    output int             pending,
    output int             words_seen,
    output int             results_seen
);
    import fa2b_pkg::*;

    localparam logic [31:0] START_CODE = 32'h0000_0001;

    out_t        annexb_q[$];
    out_t        byte_res[4];
    int          byte_n;
    out_t        exp_r;

    logic [2:0]  prefix_reg;
    phase_t      ph;
    logic [2:0]  hdr_cnt;
    logic [1:0]  pfx_cnt;
    logic [31:0] nal_left;
    logic [3:0]  held_ft;
    logic [3:0]  held_cid;
    logic [7:0]  held_pt;
    logic [23:0] held_ct;

    task automatic add_result(input logic [1:0] k, input logic [7:0] d, input logic [3:0] f,
                              input logic [3:0] c, input logic [7:0] p, input logic [23:0] t,
                              input logic done);
        out_t r;
        r.kind = k;
        r.data_byte = d;
        r.frame_type = f;
        r.codec_id = c;
        r.packet_type = p;
        r.composition_time = t;
        r.run_last = 1'b0;
        r.tag_done = done;
        byte_res[byte_n] = r;
        byte_n++;
    endtask

    task automatic convert_byte(input in_t w);
        logic [7:0] b;
        logic       fin;
        logic [3:0] ft;
        logic [3:0] cid;
        int         need;
        int         got;
        int         i;
        b = w.in_byte;
        fin = w.tag_end;
        ft = held_ft;
        cid = held_cid;
        byte_n = 0;
        case (ph)
            PH_HEAD:
            begin
                if (hdr_cnt == 0)
                    held_pt = b;
                else
                    held_ct = {held_ct[15:0], b};
                hdr_cnt = hdr_cnt + 3'd1;
                if (hdr_cnt >= 3'd4)
                begin
                    hdr_cnt = 3'd0;
                    add_result(KIND_HDR, 8'h00, ft, cid, held_pt, held_ct,
                               fin || held_pt != PT_NALU);
                    ph = (held_pt == PT_NALU) ? PH_PREFIX : PH_DROP;
                end
                else if (fin)
                    add_result(KIND_TRUNC, 8'h00, ft, cid, 8'h00, 24'h0, 1'b1);
            end
            PH_PREFIX:
            begin
                need = int'(prefix_reg);
                if (need < int'(PREFIX_MIN))
                    need = int'(PREFIX_MIN);
                if (need > int'(PREFIX_MAX))
                    need = int'(PREFIX_MAX);
                got = int'(pfx_cnt) + 1;
                nal_left = {nal_left[23:0], b};
                if (got >= need)
                begin
                    pfx_cnt = 2'd0;
                    if (fin && nal_left != 0)
                        add_result(KIND_TRUNC, 8'h00, ft, cid, held_pt, held_ct, 1'b1);
                    else
                    begin
                        for (i = 0; i < 4; i++)
                            add_result(KIND_BYTE, START_CODE[8 * (3 - i) +: 8], 4'h0, 4'h0,
                                       8'h00, 24'h0, fin && i == 3);
                        ph = (nal_left != 0) ? PH_BODY : PH_PREFIX;
                    end
                end
                else
                begin
                    pfx_cnt = got[1:0];
                    if (fin)
                        add_result(KIND_TRUNC, 8'h00, ft, cid, held_pt, held_ct, 1'b1);
                end
            end
            PH_BODY:
            begin
                nal_left = nal_left - 32'd1;
                add_result(KIND_BYTE, b, 4'h0, 4'h0, 8'h00, 24'h0, fin && nal_left == 0);
                if (fin && nal_left != 0)
                    add_result(KIND_TRUNC, 8'h00, ft, cid, held_pt, held_ct, 1'b1);
                if (nal_left == 0)
                    ph = PH_PREFIX;
            end
            PH_DROP:
            begin
            end
            default:
            begin
                ft = b[7:4];
                cid = b[3:0];
                held_ft = ft;
                held_cid = cid;
                held_pt = 8'h00;
                held_ct = 24'h0;
                hdr_cnt = 3'd0;
                pfx_cnt = 2'd0;
                nal_left = 32'd0;
                if (cid != CODEC_AVC)
                begin
                    add_result(KIND_UNSUP, 8'h00, ft, cid, 8'h00, 24'h0, 1'b1);
                    ph = PH_DROP;
                end
                else
                begin
                    if (fin)
                        add_result(KIND_TRUNC, 8'h00, ft, cid, 8'h00, 24'h0, 1'b1);
                    ph = PH_HEAD;
                end
            end
        endcase
        if (fin)
        begin
            ph = PH_FIRST;
            hdr_cnt = 3'd0;
            pfx_cnt = 2'd0;
            nal_left = 32'd0;
        end
        if (byte_n > 0)
            byte_res[byte_n - 1].run_last = 1'b1;
        for (i = 0; i < byte_n; i++)
            annexb_q.push_back(byte_res[i]);
    endtask

    task automatic flag(input string what, input out_t e, input out_t a);
        if (errors < 10)
            $display("%0t %s: exp kind=%0d data=%02h ft=%0d cid=%0d pt=%02h ct=%06h rl=%0b td=%0b",
                     $realtime, what, e.kind, e.data_byte, e.frame_type, e.codec_id,
                     e.packet_type, e.composition_time, e.run_last, e.tag_done);
        if (errors < 10)
            $display("%0t %s: got kind=%0d data=%02h ft=%0d cid=%0d pt=%02h ct=%06h rl=%0b td=%0b",
                     $realtime, what, a.kind, a.data_byte, a.frame_type, a.codec_id,
                     a.packet_type, a.composition_time, a.run_last, a.tag_done);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg = PREFIX_RESET;
            ph = PH_FIRST;
            hdr_cnt = 3'd0;
            pfx_cnt = 2'd0;
            nal_left = 32'd0;
            held_ft = 4'h0;
            held_cid = 4'h0;
            held_pt = 8'h00;
            held_ct = 24'h0;
            annexb_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                prefix_reg = cfg_data;
            if (pop && !empty)
            begin
                results_seen++;
                if (annexb_q.size() == 0)
                    flag("unexpected word", '0, out_word);
                else
                begin
                    exp_r = annexb_q.pop_front();
                    if (out_word.kind !== exp_r.kind
                        || out_word.data_byte !== exp_r.data_byte
                        || out_word.frame_type !== exp_r.frame_type
                        || out_word.codec_id !== exp_r.codec_id
                        || out_word.packet_type !== exp_r.packet_type
                        || out_word.composition_time !== exp_r.composition_time
                        || out_word.run_last !== exp_r.run_last
                        || out_word.tag_done !== exp_r.tag_done)
                        flag("mismatch", exp_r, out_word);
                end
            end
            if (push && !full)
            begin
                words_seen++;
                convert_byte(in_word);
            end
            pending = annexb_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives FLV video tag bodies into the Annex-B converter: a directed set of
// corner-case tags, then random well-formed, cut-short and noise tags under
// a range of prefix widths, with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
module tb;
    import fa2b_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int WORD_TARGET = 500;
    localparam int TAGS_PER_SETTING = 5;

    // {tag byte, last byte of tag}
    localparam logic [8:0] DIRECTED [34] = '{
        {8'hF2, 1'b0}, {8'h55, 1'b1},
        {8'h17, 1'b1},
        {8'h27, 1'b0}, {8'h01, 1'b0}, {8'h00, 1'b1},
        {8'h17, 1'b0}, {8'h00, 1'b0}, {8'h12, 1'b0}, {8'h34, 1'b0}, {8'h56, 1'b0},
        {8'h99, 1'b1},
        {8'h17, 1'b0}, {8'h01, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b1},
        {8'h17, 1'b0}, {8'h01, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
        {8'h00, 1'b0}, {8'h02, 1'b0}, {8'h00, 1'b0}, {8'hFF, 1'b0}, {8'h03, 1'b0},
        {8'h80, 1'b1},
        {8'h17, 1'b0}, {8'h01, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0},
        {8'h01, 1'b1}
    };

    localparam logic [2:0] PREFIX_PLAN [8] = '{
        3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5, 3'd6, 3'd1
    };

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_t        in_word;
    logic       empty;
    logic       pop;
    out_t       out_word;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_data;

    int         errors;
    int         pending;
    int         words_seen;
    int         results_seen;
    int         stall_cycles;
    int         words_sent;
    int         tags_sent;
    int         settings;
    logic [2:0] prefix_now;
    logic       src_idle;

    flv_avc_tag_to_annexb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fa2b_annexb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_word      (in_word),
        .empty        (empty),
        .pop          (pop),
        .out_word     (out_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .words_seen   (words_seen),
        .results_seen (results_seen)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_word(input logic [7:0] b, input logic fin);
        int gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        in_word <= '{in_byte: b, tag_end: fin};
        do
            @(posedge clk);
        while (full);
        words_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        wait (pending == 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_prefix(input logic [2:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        prefix_now = v;
        settings++;
    endtask

    // result side
    initial
    begin
        int   gap;
        logic snk_idle;
        pop = 1'b0;
        snk_idle = 1'b1;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                snk_idle = !snk_idle;
            gap = snk_idle ? $urandom_range(0, 5) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    initial
    begin
        logic [7:0] tag_bytes[$];
        int         pick;
        int         n_nal;
        int         len;
        int         width;
        int         cut;
        int         plan_idx;
        int         tags_here;
        int         i;
        int         j;
        int         k;
        logic [3:0] codec;
        logic [7:0] pt;

        rst_n = 1'b0;
        push = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_data = 3'd0;
        prefix_now = PREFIX_RESET;
        src_idle = 1'b1;
        plan_idx = 0;
        tags_here = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_prefix(PREFIX_MIN);
        for (i = 0; i < 34; i++)
            send_word(DIRECTED[i][8:1], DIRECTED[i][0]);
        tags_sent = 7;
        settle();

        while (words_sent < WORD_TARGET)
        begin
            if (tags_here == TAGS_PER_SETTING)
            begin
                settle();
                if (plan_idx < 8)
                    write_prefix(PREFIX_PLAN[plan_idx]);
                else
                    write_prefix(3'($urandom_range(0, 7)));
                plan_idx++;
                tags_here = 0;
            end
            src_idle = ($urandom_range(0, 2) != 0);
            width = (prefix_now < PREFIX_MIN) ? int'(PREFIX_MIN)
                  : (prefix_now > PREFIX_MAX) ? int'(PREFIX_MAX) : int'(prefix_now);
            tag_bytes.delete();
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // noise
                len = $urandom_range(1, 8);
                for (j = 0; j < len; j++)
                    tag_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick == 1)
            begin
                do
                    codec = 4'($urandom_range(0, 15));
                while (codec == CODEC_AVC);
                tag_bytes.push_back({4'($urandom_range(0, 15)), codec});
                len = $urandom_range(0, 4);
                for (j = 0; j < len; j++)
                    tag_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                tag_bytes.push_back({4'($urandom_range(0, 15)), CODEC_AVC});
                pt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : PT_NALU;
                tag_bytes.push_back(pt);
                for (j = 0; j < 3; j++)
                    tag_bytes.push_back(8'($urandom_range(0, 255)));
                if (pt == PT_NALU)
                begin
                    n_nal = $urandom_range(0, 3);
                    for (j = 0; j < n_nal; j++)
                    begin
                        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                        for (k = width - 1; k >= 0; k--)
                            tag_bytes.push_back(8'(len >> (8 * k)));
                        for (k = 0; k < len; k++)
                            tag_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
                else
                begin
                    len = $urandom_range(0, 4);
                    for (j = 0; j < len; j++)
                        tag_bytes.push_back(8'($urandom_range(0, 255)));
                end
                if (pick == 2)
                begin
                    // cut short
                    cut = $urandom_range(1, tag_bytes.size());
                    while (tag_bytes.size() > cut)
                        void'(tag_bytes.pop_back());
                end
            end
            for (j = 0; j < tag_bytes.size(); j++)
                send_word(tag_bytes[j], j == tag_bytes.size() - 1);
            tags_sent++;
            tags_here++;
        end

        settle();
        repeat (10) @(posedge clk);
        $display("run covered %0d tags, %0d tag bytes and %0d result words",
                 tags_sent, words_seen, results_seen);
        $display("over %0d prefix-width settings, %0d mismatches", settings, errors);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/fa2b_pkg.sv
rtl/fa2b_front.sv
rtl/fa2b_cmd_fifo.sv
rtl/fa2b_back.sv
rtl/flv_avc_tag_to_annexb.sv
rtl/fa2b_checker.sv
tb/fa2b_annexb_checker.sv
tb/tb.sv
